/* rtl/button_press_classifier_macros.svh */
// Assertion macros for the button press classifier
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define BPC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define BPC_ASSERT(lbl, prop, msg)

`define BPC_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* rtl/bpc_pkg.sv */
package bpc_pkg;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_DOUBLE   = 2'd2,
    CFG_DBL_EN   = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  DebounceRst = 8'd5;
  localparam logic [15:0] LongRst     = 16'd1000;
  localparam logic [15:0] DoubleRst   = 16'd500;
  localparam logic        DblEnRst    = 1'b1;

  localparam logic [7:0]  DcntMax = 8'hFF;

  typedef struct packed {
    logic short_press;
    logic double_press;
    logic long_press;
    logic pressed;
  } result_t;

endpackage

/* rtl/bpc_step.sv */
module bpc_step
  import bpc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                   pin_level_i,
  input  logic                   stable_q_i,
  input  logic                   pend_q_i,
  input  logic [7:0]             dcnt_q_i,
  input  logic [TIMER_WIDTH-1:0] press_q_i,
  input  logic                   long_done_q_i,
  input  logic [TIMER_WIDTH-1:0] since_q_i,
  input  logic                   win_q_i,
  input  logic [7:0]             cfg_debounce_i,
  input  logic [15:0]            cfg_long_i,
  input  logic [15:0]            cfg_double_i,
  input  logic                   cfg_dbl_en_i,
  output logic                   stable_d_o,
  output logic                   pend_d_o,
  output logic [7:0]             dcnt_d_o,
  output logic [TIMER_WIDTH-1:0] press_d_o,
  output logic                   long_done_d_o,
  output logic [TIMER_WIDTH-1:0] since_d_o,
  output logic                   win_d_o,
  output result_t                res_o
);

  localparam int unsigned CmpW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

  logic [TIMER_WIDTH-1:0] press_inc;
  logic [TIMER_WIDTH-1:0] since_inc;
  logic [7:0]             dcnt_inc;
  logic [CmpW-1:0]        press_x;
  logic [CmpW-1:0]        since_x;

  always_comb begin
    press_inc = press_q_i;
    if (!stable_q_i && (press_q_i != TimerMax)) begin
      press_inc = press_q_i + 1'b1;
    end
    since_inc = since_q_i;
    if (win_q_i && (since_q_i != TimerMax)) begin
      since_inc = since_q_i + 1'b1;
    end
    dcnt_inc = (dcnt_q_i == DcntMax) ? DcntMax : dcnt_q_i + 8'd1;
    press_x  = CmpW'(press_inc);
    since_x  = CmpW'(since_inc);

    stable_d_o    = stable_q_i;
    pend_d_o      = pend_q_i;
    dcnt_d_o      = dcnt_q_i;
    press_d_o     = press_inc;
    long_done_d_o = long_done_q_i;
    since_d_o     = since_inc;
    win_d_o       = win_q_i;
    res_o         = '0;

    if (pend_q_i) begin
      dcnt_d_o = dcnt_inc;
      if (dcnt_inc >= cfg_debounce_i) begin
        pend_d_o = 1'b0;
        dcnt_d_o = '0;
        if (pin_level_i != stable_q_i) begin
          stable_d_o = pin_level_i;
          if (!pin_level_i) begin
            press_d_o     = '0;
            long_done_d_o = 1'b0;
          end else if ((press_x < CmpW'(cfg_long_i)) &&
                       (press_x > CmpW'(cfg_debounce_i))) begin
            res_o.short_press = 1'b1;
            since_d_o         = '0;
            if (cfg_dbl_en_i && win_q_i && (since_x < CmpW'(cfg_double_i))) begin
              res_o.double_press = 1'b1;
              win_d_o            = 1'b0;
            end else begin
              win_d_o = 1'b1;
            end
          end
        end
      end
    end else if (pin_level_i != stable_q_i) begin
      pend_d_o = 1'b1;
      dcnt_d_o = '0;
    end else if (!pin_level_i && !long_done_q_i) begin
      if (press_x >= CmpW'(cfg_long_i)) begin
        res_o.long_press = 1'b1;
        long_done_d_o    = 1'b1;
      end
    end

    res_o.pressed = !stable_d_o;
  end

endmodule

/* rtl/button_press_classifier.sv */
// Debounced button press classifier: short, double and long press events.
// A result is registered and valid in the cycle after its item is accepted.
// Throughput: one item per cycle while the result side takes every result;
// a single output register decouples the two sides.
// Reset: asynchronous, active low; state and config registers return to their
// defaults (the result register is not reset), the button reads released and no result is pending.
`include "button_press_classifier_macros.svh"

module button_press_classifier
  import bpc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                pin_level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                short_press_o,
  output logic                double_press_o,
  output logic                long_press_o,
  output logic                pressed_o
);

  logic [7:0]  cfg_debounce_q;
  logic [15:0] cfg_long_q;
  logic [15:0] cfg_double_q;
  logic        cfg_dbl_en_q;

  logic                   stable_q, stable_d;
  logic                   pend_q, pend_d;
  logic [7:0]             dcnt_q, dcnt_d;
  logic [TIMER_WIDTH-1:0] press_q, press_d;
  logic                   long_done_q, long_done_d;
  logic [TIMER_WIDTH-1:0] since_q, since_d;
  logic                   win_q, win_d;

  result_t res_d, res_q;
  logic    out_valid_q;
  logic    in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_debounce_q <= DebounceRst;
      cfg_long_q     <= LongRst;
      cfg_double_q   <= DoubleRst;
      cfg_dbl_en_q   <= DblEnRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: cfg_debounce_q <= cfg_data_i[7:0];
        CFG_LONG:     cfg_long_q     <= cfg_data_i;
        CFG_DOUBLE:   cfg_double_q   <= cfg_data_i;
        CFG_DBL_EN:   cfg_dbl_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bpc_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .pin_level_i    (pin_level_i),
    .stable_q_i     (stable_q),
    .pend_q_i       (pend_q),
    .dcnt_q_i       (dcnt_q),
    .press_q_i      (press_q),
    .long_done_q_i  (long_done_q),
    .since_q_i      (since_q),
    .win_q_i        (win_q),
    .cfg_debounce_i (cfg_debounce_q),
    .cfg_long_i     (cfg_long_q),
    .cfg_double_i   (cfg_double_q),
    .cfg_dbl_en_i   (cfg_dbl_en_q),
    .stable_d_o     (stable_d),
    .pend_d_o       (pend_d),
    .dcnt_d_o       (dcnt_d),
    .press_d_o      (press_d),
    .long_done_d_o  (long_done_d),
    .since_d_o      (since_d),
    .win_d_o        (win_d),
    .res_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q    <= 1'b1;
      pend_q      <= 1'b0;
      dcnt_q      <= '0;
      press_q     <= '0;
      long_done_q <= 1'b0;
      since_q     <= '0;
      win_q       <= 1'b0;
    end else if (in_fire) begin
      stable_q    <= stable_d;
      pend_q      <= pend_d;
      dcnt_q      <= dcnt_d;
      press_q     <= press_d;
      long_done_q <= long_done_d;
      since_q     <= since_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign short_press_o  = res_q.short_press;
  assign double_press_o = res_q.double_press;
  assign long_press_o   = res_q.long_press;
  assign pressed_o      = res_q.pressed;

  `BPC_ASSERT(a_fire_gives_result, in_fire |=> out_valid_o, "accepted item gave no result")
  `BPC_ASSERT_NEVER(a_double_needs_short,
                    out_valid_o && double_press_o && !short_press_o,
                    "double press without short press")
  `BPC_ASSERT_NEVER(a_long_while_held,
                    out_valid_o && long_press_o && !pressed_o,
                    "long press while released")
  `BPC_ASSERT_NEVER(a_short_on_release,
                    out_valid_o && short_press_o && pressed_o,
                    "short press while held")

endmodule
